/* rtl/tpsh_pkg.sv */
// Shared types, constants and mixing functions for the triple polynomial stream hash.
`timescale 1ns / 1ps

package tpsh_pkg;

  localparam logic [63:0] INIT_A   = 64'd123456789;
  localparam logic [63:0] INIT_B   = 64'd314159265;
  localparam logic [63:0] INIT_C   = 64'd958473711;
  localparam logic [31:0] INIT_MIX = 32'hCAFEBABE;
  localparam logic        MODE_RESET = 1'b1;
  localparam logic        MODE_STRING = 1'b0;

  typedef struct packed {
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
  } fold_t;

  // accumulator snapshot handed from the accumulate stage to the fold pipeline
  typedef struct packed {
    fold_t       lo;
    fold_t       hi;
    logic [31:0] mix;
    logic        mode;
  } snap_t;

  // one row (three lines) of the 96-bit mix
  function automatic fold_t fold_row(input fold_t s, input logic [4:0] sa,
                                     input logic [4:0] sb, input logic [4:0] sc);
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
    fold_t       r;
    x = s.x;
    y = s.y;
    z = s.z;
    x = x - y; x = x - z; x = x ^ (z >> sa);
    y = y - z; y = y - x; y = y ^ (x << sb);
    z = z - x; z = z - y; z = z ^ (y >> sc);
    r.x = x;
    r.y = y;
    r.z = z;
    return r;
  endfunction

  function automatic logic [31:0] mix_final(input logic [31:0] m_in);
    logic [31:0] m;
    m = m_in;
    m = m + (m << 3);
    m = m ^ (m >> 11);
    m = m + (m << 15);
    return m;
  endfunction

endpackage

/* rtl/tpsh_accum.sv */
// Input word register, polynomial accumulators, one-at-a-time mixer and mode register.
`timescale 1ns / 1ps

module tpsh_accum
  import tpsh_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic        cfg_wr_data,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [31:0] element_value
  input  logic        in_tuser,   // has_value
  input  logic        in_tlast,
  output logic        snap_valid,
  input  logic        snap_ready,
  output snap_t       snap
);

  logic        mode_r;
  logic        in_valid_r;
  logic [31:0] elem_r;
  logic        has_r;
  logic        last_r;
  logic [63:0] acc_a_r, acc_b_r, acc_c_r;
  logic [31:0] mix_r;
  logic [63:0] acc_a_nxt, acc_b_nxt, acc_c_nxt;
  logic [31:0] mix_nxt;
  logic [63:0] ext;
  logic [31:0] m1, m2;
  logic        adv;

  assign adv       = in_valid_r && (!last_r || snap_ready);
  assign in_tready = !in_valid_r || adv;

  assign ext = {{32{elem_r[31]}}, elem_r};
  assign m1  = mix_r + elem_r;
  assign m2  = m1 + (m1 << 10);

  always_comb begin
    if (has_r) begin
      acc_a_nxt = (acc_a_r << 5) - acc_a_r + ext;
      acc_b_nxt = (acc_b_r << 8) + (acc_b_r << 6) - (acc_b_r << 2) + acc_b_r + ext;
      acc_c_nxt = (acc_c_r << 10) + (acc_c_r << 9) + (acc_c_r << 6) + (acc_c_r << 3)
                  + acc_c_r + ext;
      mix_nxt   = m2 ^ (m2 >> 6);
    end else begin
      acc_a_nxt = acc_a_r;
      acc_b_nxt = acc_b_r;
      acc_c_nxt = acc_c_r;
      mix_nxt   = mix_r;
    end
  end

  assign snap_valid = in_valid_r && last_r;
  assign snap.lo    = '{x: acc_a_nxt[31:0],  y: acc_b_nxt[63:32], z: acc_c_nxt[31:0]};
  assign snap.hi    = '{x: acc_a_nxt[63:32], y: acc_b_nxt[31:0],  z: acc_c_nxt[63:32]};
  assign snap.mix   = mix_nxt;
  assign snap.mode  = mode_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r     <= MODE_RESET;
      in_valid_r <= 1'b0;
      acc_a_r    <= INIT_A;
      acc_b_r    <= INIT_B;
      acc_c_r    <= INIT_C;
      mix_r      <= INIT_MIX;
    end else begin
      if (cfg_wr_en) begin
        mode_r <= cfg_wr_data;
      end
      if (in_tready) begin
        in_valid_r <= in_tvalid;
      end
      if (adv) begin
        if (last_r) begin
          acc_a_r <= INIT_A;
          acc_b_r <= INIT_B;
          acc_c_r <= INIT_C;
          mix_r   <= INIT_MIX;
        end else begin
          acc_a_r <= acc_a_nxt;
          acc_b_r <= acc_b_nxt;
          acc_c_r <= acc_c_nxt;
          mix_r   <= mix_nxt;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      elem_r <= in_tdata;
      has_r  <= in_tuser;
      last_r <= in_tlast;
    end
  end

  a_restart: assert property (@(posedge clk) disable iff (!rst_n)
    adv && last_r |=> acc_a_r == INIT_A && acc_b_r == INIT_B && acc_c_r == INIT_C
                      && mix_r == INIT_MIX)
    else $error("accumulators not restored after closing word");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> $stable(acc_a_r) && $stable(acc_b_r) && $stable(acc_c_r) && $stable(mix_r))
    else $error("accumulator changed without a word");

  a_skip: assert property (@(posedge clk) disable iff (!rst_n)
    adv && !has_r && !last_r |=> $stable(acc_a_r) && $stable(mix_r))
    else $error("word without value changed state");

endmodule

/* rtl/tpsh_fold.sv */
// Three-stage 96-bit fold pipeline with mixer finalize and output register.
`timescale 1ns / 1ps

module tpsh_fold
  import tpsh_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        snap_valid,
  output logic        snap_ready,
  input  snap_t       snap,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata
);

  logic        p1_valid_r, p2_valid_r, p3_valid_r, out_valid_r;
  snap_t       p1_r, p2_r, p3_r;
  logic [63:0] out_data_r;
  logic        rdy1, rdy2, rdy3, out_slot;
  snap_t       p2_nxt, p3_nxt;
  fold_t       lo3, hi3;
  logic [31:0] lo_fin, hi_fin;

  assign out_slot   = !out_valid_r || out_tready;
  assign rdy3       = !p3_valid_r || out_slot;
  assign rdy2       = !p2_valid_r || rdy3;
  assign rdy1       = !p1_valid_r || rdy2;
  assign snap_ready = rdy1;

  always_comb begin
    p2_nxt      = p1_r;
    p2_nxt.lo   = fold_row(p1_r.lo, 5'd13, 5'd8, 5'd13);
    p2_nxt.hi   = fold_row(p1_r.hi, 5'd13, 5'd8, 5'd13);
    p2_nxt.mix  = mix_final(p1_r.mix);
    p3_nxt      = p2_r;
    p3_nxt.lo   = fold_row(p2_r.lo, 5'd12, 5'd16, 5'd5);
    p3_nxt.hi   = fold_row(p2_r.hi, 5'd12, 5'd16, 5'd5);
    lo3         = fold_row(p3_r.lo, 5'd3, 5'd10, 5'd15);
    hi3         = fold_row(p3_r.hi, 5'd3, 5'd10, 5'd15);
    if (p3_r.mode == MODE_STRING) begin
      lo_fin = lo3.z;
      hi_fin = hi3.z;
    end else begin
      lo_fin = lo3.z + p3_r.mix;
      hi_fin = hi3.z ^ p3_r.mix;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_valid_r  <= 1'b0;
      p2_valid_r  <= 1'b0;
      p3_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (rdy1) p1_valid_r <= snap_valid;
      if (rdy2) p2_valid_r <= p1_valid_r;
      if (rdy3) p3_valid_r <= p2_valid_r;
      if (out_slot) out_valid_r <= p3_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1) p1_r <= snap;
    if (rdy2) p2_r <= p2_nxt;
    if (rdy3) p3_r <= p3_nxt;
    if (out_slot) out_data_r <= {hi_fin, lo_fin};
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  a_p1_keep: assert property (@(posedge clk) disable iff (!rst_n)
    p1_valid_r && !rdy2 |=> p1_valid_r)
    else $error("stage 1 word dropped under stall");

  a_p3_move: assert property (@(posedge clk) disable iff (!rst_n)
    p3_valid_r && out_slot |=> out_valid_r)
    else $error("stage 3 word did not reach output");

  a_stall: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_tready |-> !rdy3 || !p3_valid_r)
    else $error("stage 3 advanced into a held output");

endmodule

/* rtl/triple_polynomial_stream_hash.sv */
// Top level of the triple polynomial stream hash.
`timescale 1ns / 1ps

// Hashes a message streamed one signed 32-bit word per cycle into three 64-bit
// polynomial accumulators (x31, x317, x1609) and a one-at-a-time mixer; in_tuser
// high absorbs the word, in_tlast closes the message. Throughput is one word per
// cycle, set by the accumulator update loop, unless a closing word waits on a
// stalled fold pipeline. A message's 64-bit hash passes from the input word
// register through p1, p2 and p3 and three rows of the 96-bit fold, the last
// folded into the output register. cfg_wr_en writes the mode (1 after reset:
// mixer folded into the result; 0: string variant); write it only while idle.
module triple_polynomial_stream_hash
  import tpsh_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic        cfg_wr_data,  // variant_mode
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,     // [31:0] element_value
  input  logic        in_tuser,     // has_value
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata     // [63:0] hash_value
);

  logic  snap_valid;
  logic  snap_ready;
  snap_t snap;

  tpsh_accum u_accum (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .snap_valid (snap_valid),
    .snap_ready (snap_ready),
    .snap       (snap)
  );

  tpsh_fold u_fold (
    .clk        (clk),
    .rst_n      (rst_n),
    .snap_valid (snap_valid),
    .snap_ready (snap_ready),
    .snap       (snap),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule
